/* hdl/lbcr_pkg.sv */
package lbcr_pkg;

	typedef struct packed {
		logic [7:0] sense_sample;
		logic       blink_in;
	} in_t;

	typedef struct packed {
		logic [7:0] duty;
		logic       shutdown;
		logic       sample_used;
		logic       bright_band;
	} out_t;

	localparam int CfgIdxW = 3;

	localparam logic [CfgIdxW-1:0] CFG_DIM_LEVEL      = 3'd0;
	localparam logic [CfgIdxW-1:0] CFG_BRIGHT_LEVEL   = 3'd1;
	localparam logic [CfgIdxW-1:0] CFG_BAND_WIDTH     = 3'd2;
	localparam logic [CfgIdxW-1:0] CFG_PANIC_LEVEL    = 3'd3;
	localparam logic [CfgIdxW-1:0] CFG_PANIC_LIMIT    = 3'd4;
	localparam logic [CfgIdxW-1:0] CFG_SETTLE_SKIP    = 3'd5;
	localparam logic [CfgIdxW-1:0] CFG_TICK_PRESCALE  = 3'd6;
	localparam logic [CfgIdxW-1:0] CFG_PATTERN_LENGTH = 3'd7;

	localparam logic [7:0] RST_DIM_LEVEL      = 8'd30;
	localparam logic [7:0] RST_BRIGHT_LEVEL   = 8'd125;
	localparam logic [7:0] RST_BAND_WIDTH     = 8'd10;
	localparam logic [7:0] RST_PANIC_LEVEL    = 8'd225;
	localparam logic [7:0] RST_PANIC_LIMIT    = 8'd50;
	localparam logic [7:0] RST_SETTLE_SKIP    = 8'd3;
	localparam logic [7:0] RST_TICK_PRESCALE  = 8'd100;
	localparam logic [7:0] RST_PATTERN_LENGTH = 8'd100;

	localparam logic [7:0] DUTY_PANIC_STEP = 8'd5;
	localparam logic [7:0] DUTY_FAST_STEP  = 8'd10;
	localparam logic [7:0] DUTY_SLOW_STEP  = 8'd1;
	localparam logic [7:0] FAST_THRESHOLD  = 8'd30;

	localparam logic [7:0] DIM_TICK_A = 8'd2;
	localparam logic [7:0] DIM_TICK_B = 8'd4;
	localparam logic [7:0] DIM_TICK_C = 8'd6;

	function automatic logic [7:0] sat_add8(input logic [7:0] a, input logic [7:0] b);
		logic [8:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[8] ? 8'hFF : s[7:0];
	endfunction

	function automatic logic [7:0] sat_sub8(input logic [7:0] a, input logic [7:0] b);
		return (a > b) ? (a - b) : 8'd0;
	endfunction

endpackage

/* hdl/led_buck_current_regulator.sv */
// Channel   Direction  Payload          Handshake
// in        input      lbcr_pkg::in_t   in_valid / in_stall
// out       output     lbcr_pkg::out_t  out_valid / out_stall
// cfg       input      8-bit register   cfg_wr_en / cfg_addr / cfg_wdata
//
// One item per cycle sustained while out_stall is low. The input register holds the item,
// and the regulator state and the result register are then updated together in one pass
// of compare and step logic.
// Reset clears the regulator state and loads the default register values.
// A stalled result holds in the output register while one more item waits in the
// input register; in_stall rises only when both are full.
module led_buck_current_regulator (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  lbcr_pkg::in_t                in_data,
	output logic                         out_valid,
	input  logic                         out_stall,
	output lbcr_pkg::out_t               out_data,
	input  logic                         cfg_wr_en,
	input  logic [lbcr_pkg::CfgIdxW-1:0] cfg_addr,
	input  logic [7:0]                   cfg_wdata
);
	import lbcr_pkg::*;

	logic [7:0] dim_level_q, bright_level_q, band_width_q, panic_level_q;
	logic [7:0] panic_limit_q, settle_skip_q, tick_prescale_q, pattern_length_q;

	logic [7:0] duty_q, skip_q, prescale_q, tick_q, panic_q;
	logic       bright_q, halted_q;

	logic       valid_s1;
	in_t        data_s1;
	logic       out_valid_q;
	out_t       out_data_q;

	logic       advance;

	logic       act;
	logic [7:0] pre_inc, pre_nx, tick_inc, tick_nx;
	logic       bright_nx;
	logic [7:0] lo, hi, shortfall;
	logic [8:0] hi_sum;
	logic [7:0] duty_reg_nx, panic_nx, skip_nx;
	logic       halted_nx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dim_level_q      <= RST_DIM_LEVEL;
			bright_level_q   <= RST_BRIGHT_LEVEL;
			band_width_q     <= RST_BAND_WIDTH;
			panic_level_q    <= RST_PANIC_LEVEL;
			panic_limit_q    <= RST_PANIC_LIMIT;
			settle_skip_q    <= RST_SETTLE_SKIP;
			tick_prescale_q  <= RST_TICK_PRESCALE;
			pattern_length_q <= RST_PATTERN_LENGTH;
		end else if (cfg_wr_en) begin
			case (cfg_addr)
				CFG_DIM_LEVEL:      dim_level_q      <= cfg_wdata;
				CFG_BRIGHT_LEVEL:   bright_level_q   <= cfg_wdata;
				CFG_BAND_WIDTH:     band_width_q     <= cfg_wdata;
				CFG_PANIC_LEVEL:    panic_level_q    <= cfg_wdata;
				CFG_PANIC_LIMIT:    panic_limit_q    <= cfg_wdata;
				CFG_SETTLE_SKIP:    settle_skip_q    <= cfg_wdata;
				CFG_TICK_PRESCALE:  tick_prescale_q  <= cfg_wdata;
				CFG_PATTERN_LENGTH: pattern_length_q <= cfg_wdata;
				default: begin
				end
			endcase
		end
	end

	// The input register moves on whenever the result register is empty or being taken.
	assign advance  = !out_valid_q || !out_stall;
	assign in_stall = valid_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			data_s1 <= in_data;
		end
	end

	always_comb begin
		act = !halted_q && (skip_q > settle_skip_q);

		// Blink pattern.
		pre_inc  = sat_add8(prescale_q, 8'd1);
		tick_inc = tick_q;
		pre_nx   = pre_inc;
		if (pre_inc > tick_prescale_q) begin
			tick_inc = tick_q + 8'd1;
			pre_nx   = 8'd0;
		end
		tick_nx   = tick_inc;
		bright_nx = bright_q;
		if (tick_inc == DIM_TICK_A || tick_inc == DIM_TICK_B || tick_inc == DIM_TICK_C) begin
			bright_nx = 1'b0;
		end else if (tick_inc == pattern_length_q) begin
			tick_nx = 8'd0;
		end else begin
			bright_nx = 1'b1;
		end
		if (!data_s1.blink_in) begin
			bright_nx = 1'b0;
			tick_nx   = 8'd0;
			pre_nx    = 8'd0;
		end

		// Duty step against the band that was just selected.
		lo          = bright_nx ? bright_level_q : dim_level_q;
		hi_sum      = {1'b0, lo} + {1'b0, band_width_q};
		hi          = hi_sum[8] ? 8'hFF : hi_sum[7:0];
		shortfall   = lo - data_s1.sense_sample;
		duty_reg_nx = duty_q;
		panic_nx    = panic_q;
		if (data_s1.sense_sample > panic_level_q) begin
			duty_reg_nx = sat_sub8(duty_q, DUTY_PANIC_STEP);
			panic_nx    = sat_add8(panic_q, 8'd1);
		end else if (data_s1.sense_sample < lo) begin
			duty_reg_nx = sat_add8(duty_q,
				(shortfall > FAST_THRESHOLD) ? DUTY_FAST_STEP : DUTY_SLOW_STEP);
			panic_nx    = 8'd0;
		end else if (data_s1.sense_sample > hi) begin
			duty_reg_nx = sat_sub8(duty_q, DUTY_SLOW_STEP);
		end else begin
			panic_nx = 8'd0;
		end

		// Skipped samples leave the pattern and duty untouched.
		if (!act) begin
			tick_nx     = tick_q;
			pre_nx      = prescale_q;
			bright_nx   = bright_q;
			duty_reg_nx = duty_q;
			panic_nx    = panic_q;
		end
		skip_nx = act ? 8'd0 : sat_add8(skip_q, 8'd1);

		halted_nx = halted_q;
		if (!halted_q && (panic_nx >= panic_limit_q)) begin
			halted_nx   = 1'b1;
			duty_reg_nx = 8'd0;
		end
		if (halted_q) begin
			skip_nx = skip_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			duty_q     <= 8'd0;
			skip_q     <= 8'd0;
			prescale_q <= 8'd0;
			tick_q     <= 8'd0;
			panic_q    <= 8'd0;
			bright_q   <= 1'b0;
			halted_q   <= 1'b0;
		end else if (valid_s1 && advance) begin
			duty_q     <= duty_reg_nx;
			skip_q     <= skip_nx;
			prescale_q <= pre_nx;
			tick_q     <= tick_nx;
			panic_q    <= panic_nx;
			bright_q   <= bright_nx;
			halted_q   <= halted_nx;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1 && advance) begin
			out_data_q.duty        <= halted_nx ? 8'd0 : duty_reg_nx;
			out_data_q.shutdown    <= halted_nx;
			out_data_q.sample_used <= act;
			out_data_q.bright_band <= bright_nx;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	a_shutdown_zero_duty: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_data_q.shutdown |-> out_data_q.duty == 8'd0)
		else $error("shutdown result with nonzero duty");

	a_halt_latches: assert property (@(posedge clk) disable iff (!arst_n)
		halted_q |=> halted_q && duty_q == 8'd0)
		else $error("shutdown released or duty moved while halted");

	a_stall_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> valid_s1 && out_valid_q && out_stall)
		else $error("input stalled with room in the pipeline");

	a_result_follows_item: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !out_valid_q |=> out_valid_q)
		else $error("registered item did not reach the result register");

endmodule

/* tb/tb_led_buck_current_regulator.sv */
`timescale 1ns / 100ps

module tb_led_buck_current_regulator;
	import lbcr_pkg::*;

	localparam int CLK_HALF = 6;
	localparam int RESET_CYCLES = 10;
	localparam int MAX_WAIT = 18;
	localparam int HOLD_CYCLES = 150;
	localparam int HOLD_AFTER = 500;
	localparam int CYCLE_LIMIT = 400000;
	localparam int RAND_PHASES = 16;
	localparam int PHASE_ITEMS = 100;
	localparam int SHUTDOWN_ITEMS = 60;
	localparam int DRAIN_CYCLES = 10;

	typedef struct packed {
		logic [7:0] duty;
		logic [7:0] skip;
		logic [7:0] presc;
		logic [7:0] tick;
		logic [7:0] panic;
		logic       bright;
		logic       halted;
	} regulator_state_t;

	typedef enum logic {ROW_ITEM, ROW_REG} row_kind_e;

	typedef struct {
		row_kind_e            kind;
		in_t                  item;
		bit                   known;
		out_t                 res;
		logic [CfgIdxW-1:0]   idx;
		logic [7:0]           val;
	} plan_row_t;

	logic               clk;
	logic               arst_n;
	logic               in_valid;
	logic               in_stall;
	in_t                in_data;
	logic               out_valid;
	logic               out_stall;
	out_t               out_data;
	logic               cfg_wr_en;
	logic [CfgIdxW-1:0] cfg_addr;
	logic [7:0]         cfg_wdata;

	logic [7:0]       reg_file [2**CfgIdxW];
	regulator_state_t lamp;
	out_t             pending_results [$];
	int               mismatches = 0;
	int               results_seen = 0;
	int               snd_max = MAX_WAIT;
	int               rcv_max = MAX_WAIT;
	bit               ramp_up = 1'b0;
	int               cycles = 0;

	led_buck_current_regulator i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.in_data    (in_data),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.out_data   (out_data),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_addr   (cfg_addr),
		.cfg_wdata  (cfg_wdata)
	);

	initial clk = 1'b0;
	always #(CLK_HALF) clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	// Expected result of one sample, and the regulator state it leaves behind.
	function automatic out_t regulate_sample(input regulator_state_t cur, input in_t it,
			output regulator_state_t nxt);
		int   lo;
		int   hi;
		int   s;
		int   d;
		logic used;
		out_t res;
		nxt = cur;
		used = 1'b0;
		if (!nxt.halted) begin
			if (nxt.skip > reg_file[CFG_SETTLE_SKIP]) begin
				used = 1'b1;
				if (!it.blink_in) begin
					nxt.bright = 1'b0;
					nxt.tick = 8'd0;
					nxt.presc = 8'd0;
				end else begin
					if (nxt.presc != 8'hFF)
						nxt.presc = nxt.presc + 8'd1;
					if (nxt.presc > reg_file[CFG_TICK_PRESCALE]) begin
						nxt.tick = nxt.tick + 8'd1;
						nxt.presc = 8'd0;
					end
					if (nxt.tick == DIM_TICK_A || nxt.tick == DIM_TICK_B || nxt.tick == DIM_TICK_C)
						nxt.bright = 1'b0;
					else if (nxt.tick == reg_file[CFG_PATTERN_LENGTH])
						nxt.tick = 8'd0;
					else
						nxt.bright = 1'b1;
				end
				lo = int'(nxt.bright ? reg_file[CFG_BRIGHT_LEVEL] : reg_file[CFG_DIM_LEVEL]);
				hi = lo + int'(reg_file[CFG_BAND_WIDTH]);
				if (hi > 255)
					hi = 255;
				s = int'(it.sense_sample);
				d = int'(nxt.duty);
				if (s > int'(reg_file[CFG_PANIC_LEVEL])) begin
					d = d - int'(DUTY_PANIC_STEP);
					if (nxt.panic != 8'hFF)
						nxt.panic = nxt.panic + 8'd1;
				end else if (s < lo) begin
					d = d + ((lo - s > int'(FAST_THRESHOLD)) ? int'(DUTY_FAST_STEP)
						: int'(DUTY_SLOW_STEP));
					nxt.panic = 8'd0;
				end else if (s > hi) begin
					d = d - int'(DUTY_SLOW_STEP);
				end else begin
					nxt.panic = 8'd0;
				end
				if (d < 0)
					d = 0;
				if (d > 255)
					d = 255;
				nxt.duty = d[7:0];
				nxt.skip = 8'd0;
			end else if (nxt.skip != 8'hFF) begin
				nxt.skip = nxt.skip + 8'd1;
			end
			if (nxt.panic >= reg_file[CFG_PANIC_LIMIT]) begin
				nxt.halted = 1'b1;
				nxt.duty = 8'd0;
			end
		end
		res.duty = nxt.halted ? 8'd0 : nxt.duty;
		res.shutdown = nxt.halted;
		res.sample_used = used;
		res.bright_band = nxt.bright;
		return res;
	endfunction

	// Samples cluster around the band edges, the fast-step threshold and the panic level.
	function automatic logic [7:0] pick_sample();
		int lo;
		int v;
		lo = int'(lamp.bright ? reg_file[CFG_BRIGHT_LEVEL] : reg_file[CFG_DIM_LEVEL]);
		case ($urandom_range(5, 0))
			0: v = $urandom_range(255, 0);
			1: v = $urandom_range(1, 0) ? 255 : 0;
			2: v = lo + int'($urandom_range(6, 0)) - 3;
			3: v = lo + int'(reg_file[CFG_BAND_WIDTH]) + int'($urandom_range(4, 0)) - 2;
			4: v = lo - 31 + int'($urandom_range(2, 0));
			default: v = int'(reg_file[CFG_PANIC_LEVEL]) + int'($urandom_range(2, 0)) - 1;
		endcase
		if (ramp_up && $urandom_range(3, 0) != 0)
			v = 0;
		if (v < 0)
			v = 0;
		if (v > 255)
			v = 255;
		return v[7:0];
	endfunction

	// Mode 0 gives the lowest legal value, mode 1 the highest, anything else a random one.
	function automatic logic [7:0] pick_reg(input logic [CfgIdxW-1:0] idx, input int mode);
		int lo;
		int hi;
		int v;
		lo = 0;
		hi = 255;
		case (idx)
			// The limit stays above the running panic count so that shutdown waits for the end.
			CFG_PANIC_LIMIT: lo = int'(lamp.panic) + 1;
			CFG_SETTLE_SKIP, CFG_TICK_PRESCALE: hi = 254;
			CFG_PATTERN_LENGTH: lo = 7;
			default: ;
		endcase
		if (mode == 0) begin
			v = lo;
		end else if (mode == 1) begin
			v = hi;
		end else begin
			v = $urandom_range(hi, lo);
			if ((idx == CFG_SETTLE_SKIP || idx == CFG_TICK_PRESCALE) && $urandom_range(3, 0) != 0)
				v = $urandom_range(3, 0);
			if (idx == CFG_PATTERN_LENGTH && $urandom_range(1, 0) != 0)
				v = $urandom_range(12, 7);
		end
		return v[7:0];
	endfunction

	function automatic plan_row_t item_row(input logic [7:0] s, input logic b, input bit known,
			input out_t res);
		plan_row_t r;
		r.kind = ROW_ITEM;
		r.item.sense_sample = s;
		r.item.blink_in = b;
		r.known = known;
		r.res = res;
		r.idx = '0;
		r.val = '0;
		return r;
	endfunction

	function automatic plan_row_t reg_row(input logic [CfgIdxW-1:0] idx, input logic [7:0] val);
		plan_row_t r;
		r.kind = ROW_REG;
		r.item = '0;
		r.known = 1'b0;
		r.res = '0;
		r.idx = idx;
		r.val = val;
		return r;
	endfunction

	task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [7:0] val);
		@(negedge clk);
		cfg_wr_en <= 1'b1;
		cfg_addr <= idx;
		cfg_wdata <= val;
		reg_file[idx] = val;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	// Called on a falling edge; returns on a falling edge once every result has come back.
	task automatic wait_idle();
		in_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(negedge clk);
	endtask

	// Called on a falling edge; returns on the falling edge after the item is taken.
	task automatic send_item(input in_t it, input bit known, input out_t typed, input bit guard);
		regulator_state_t nxt;
		out_t             res;
		int               gap;
		if (guard) begin
			// A used sample of zero clears the panic count, so it keeps the block running.
			res = regulate_sample(lamp, it, nxt);
			if (nxt.halted)
				it.sense_sample = 8'd0;
		end
		gap = $urandom_range(snd_max, 0);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		in_data <= it;
		do @(posedge clk); while (in_stall);
		res = regulate_sample(lamp, it, nxt);
		lamp = nxt;
		pending_results.push_back(known ? typed : res);
		@(negedge clk);
	endtask

	initial begin
		int   n;
		out_t want;
		bit   held;
		held = 1'b0;
		out_stall = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			n = $urandom_range(rcv_max, 0);
			if (!held && results_seen >= HOLD_AFTER) begin
				n = HOLD_CYCLES;
				held = 1'b1;
			end
			if (n > 0) begin
				out_stall <= 1'b1;
				repeat (n) @(negedge clk);
			end
			out_stall <= 1'b0;
			do @(posedge clk); while (!out_valid);
			results_seen++;
			if (pending_results.size() == 0) begin
				mismatches++;
				$display("%0t: unexpected result: duty %0d shutdown %0b used %0b bright %0b",
					$time, out_data.duty, out_data.shutdown, out_data.sample_used,
					out_data.bright_band);
			end else begin
				want = pending_results.pop_front();
				if (out_data.duty !== want.duty || out_data.shutdown !== want.shutdown ||
						out_data.sample_used !== want.sample_used ||
						out_data.bright_band !== want.bright_band) begin
					mismatches++;
					$display("%0t: expected duty %0d shutdown %0b used %0b bright %0b", $time,
						want.duty, want.shutdown, want.sample_used, want.bright_band);
					$display("%0t:      got duty %0d shutdown %0b used %0b bright %0b", $time,
						out_data.duty, out_data.shutdown, out_data.sample_used,
						out_data.bright_band);
				end
			end
		end
	end

	initial begin
		plan_row_t plan [$];
		out_t      skipped;
		out_t      first_acted;
		in_t       it;
		int        mode;
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		cfg_wr_en = 1'b0;
		cfg_addr = '0;
		cfg_wdata = '0;
		lamp = '0;
		reg_file[CFG_DIM_LEVEL] = RST_DIM_LEVEL;
		reg_file[CFG_BRIGHT_LEVEL] = RST_BRIGHT_LEVEL;
		reg_file[CFG_BAND_WIDTH] = RST_BAND_WIDTH;
		reg_file[CFG_PANIC_LEVEL] = RST_PANIC_LEVEL;
		reg_file[CFG_PANIC_LIMIT] = RST_PANIC_LIMIT;
		reg_file[CFG_SETTLE_SKIP] = RST_SETTLE_SKIP;
		reg_file[CFG_TICK_PRESCALE] = RST_TICK_PRESCALE;
		reg_file[CFG_PATTERN_LENGTH] = RST_PATTERN_LENGTH;

		// After reset the first four samples are skipped; the fifth, with blink low and a
		// shortfall of exactly the threshold, takes one slow step up.
		skipped = '0;
		first_acted = '0;
		first_acted.duty = 8'd1;
		first_acted.sample_used = 1'b1;
		plan.push_back(item_row(8'd0, 1'b0, 1'b1, skipped));
		plan.push_back(item_row(8'd255, 1'b1, 1'b1, skipped));
		plan.push_back(item_row(8'hAA, 1'b1, 1'b1, skipped));
		plan.push_back(item_row(8'h55, 1'b0, 1'b1, skipped));
		plan.push_back(item_row(8'd0, 1'b0, 1'b1, first_acted));

		// Every second sample acts and every acted sample with blink high ticks, so the pattern
		// walks through its dim ticks and wraps at seven.
		plan.push_back(reg_row(CFG_SETTLE_SKIP, 8'd0));
		plan.push_back(reg_row(CFG_TICK_PRESCALE, 8'd0));
		plan.push_back(reg_row(CFG_PATTERN_LENGTH, 8'd7));
		plan.push_back(reg_row(CFG_DIM_LEVEL, 8'd100));
		plan.push_back(reg_row(CFG_BRIGHT_LEVEL, 8'd200));
		plan.push_back(reg_row(CFG_BAND_WIDTH, 8'd5));
		plan.push_back(reg_row(CFG_PANIC_LEVEL, 8'd250));
		plan.push_back(item_row(8'd255, 1'b0, 1'b0, skipped));
		plan.push_back(item_row(8'd255, 1'b1, 1'b0, skipped));
		plan.push_back(item_row(8'd0, 1'b1, 1'b0, skipped));
		plan.push_back(item_row(8'd0, 1'b1, 1'b0, skipped));
		plan.push_back(item_row(8'h80, 1'b0, 1'b0, skipped));
		plan.push_back(item_row(8'd190, 1'b1, 1'b0, skipped));
		plan.push_back(item_row(8'h7F, 1'b1, 1'b0, skipped));
		plan.push_back(item_row(8'd110, 1'b1, 1'b0, skipped));
		plan.push_back(item_row(8'd1, 1'b0, 1'b0, skipped));
		plan.push_back(item_row(8'd203, 1'b1, 1'b0, skipped));
		plan.push_back(item_row(8'hFE, 1'b1, 1'b0, skipped));
		plan.push_back(item_row(8'd251, 1'b1, 1'b0, skipped));
		plan.push_back(item_row(8'd0, 1'b0, 1'b0, skipped));
		plan.push_back(item_row(8'd0, 1'b1, 1'b0, skipped));
		plan.push_back(item_row(8'h55, 1'b1, 1'b0, skipped));
		plan.push_back(item_row(8'd120, 1'b0, 1'b0, skipped));
		plan.push_back(item_row(8'hAA, 1'b1, 1'b0, skipped));
		plan.push_back(item_row(8'd99, 1'b1, 1'b0, skipped));

		repeat (RESET_CYCLES) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (plan[i]) begin
			if (plan[i].kind == ROW_REG) begin
				wait_idle();
				write_reg(plan[i].idx, plan[i].val);
			end else begin
				send_item(plan[i].item, plan[i].known, plan[i].res, 1'b0);
			end
		end

		// The first two phases put every register at its low and then its high extreme.
		for (int phase = 0; phase < RAND_PHASES; phase++) begin
			wait_idle();
			mode = (phase < 2) ? phase : 2;
			for (int k = 0; k < 2**CfgIdxW; k++)
				write_reg(CfgIdxW'(k), pick_reg(CfgIdxW'(k), mode));
			snd_max = ($urandom_range(2, 0) == 0) ? 0 : MAX_WAIT;
			rcv_max = ($urandom_range(2, 0) == 0) ? 0 : MAX_WAIT;
			ramp_up = ($urandom_range(2, 0) == 0);
			repeat (PHASE_ITEMS) begin
				it.sense_sample = pick_sample();
				it.blink_in = ($urandom_range(7, 0) != 0);
				send_item(it, 1'b0, '0, 1'b1);
			end
		end

		// Last phase: mostly over-current samples against a small limit, so the shutdown
		// latches and the samples after it must all be ignored.
		wait_idle();
		write_reg(CFG_PANIC_LEVEL, 8'($urandom_range(254, 0)));
		write_reg(CFG_PANIC_LIMIT, 8'($urandom_range(4, 1)));
		write_reg(CFG_SETTLE_SKIP, 8'($urandom_range(2, 0)));
		ramp_up = 1'b0;
		snd_max = MAX_WAIT;
		rcv_max = MAX_WAIT;
		repeat (SHUTDOWN_ITEMS) begin
			it.sense_sample = ($urandom_range(3, 0) != 0) ? 8'hFF : pick_sample();
			it.blink_in = ($urandom_range(7, 0) != 0);
			send_item(it, 1'b0, '0, 1'b0);
		end

		wait_idle();
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (mismatches == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
